FILE: rtl/core/u8sd_pkg.sv
// u8sd_pkg: shared types and constants for the utf-8 stream decoder
// holds the byte token passed from the classifier to the sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

    localparam int CODE_POINT_W = 31;
    localparam int CHAR_COUNT_W = 20;
    localparam int TOK_BITS_W   = 7;
    localparam int QUEUE_DEPTH  = 2;

    // byte ranges of the six-byte form
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC0;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD5_MIN  = 8'hF8;
    localparam logic [7:0] LEAD6_MIN  = 8'hFC;
    localparam logic [7:0] LEAD6_MAX  = 8'hFD;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    typedef enum logic [2:0] {
        TK_ZERO,
        TK_ASCII,
        TK_LEAD,
        TK_CONT,
        TK_BAD
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind              kind;
        logic [2:0]             lead_len;  // continuation bytes a lead announces
        logic [TOK_BITS_W-1:0]  bits;      // value bits carried by the byte
        logic                   last;
    } t_tok;

endpackage : u8sd_pkg

`default_nettype wire

FILE: rtl/core/utf8_stream_decoder_core.sv
// utf8_stream_decoder_core: byte-serial utf-8 decoder, six-byte form
// depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back
//
//   channel | handshake              | beat payload
//   --------+------------------------+---------------------------------------
//   in      | i_in_valid/o_in_stall  | i_data_byte, i_last_byte
//   out     | o_out_valid/i_out_stall| o_code_point, o_char_valid,
//           |                        | o_decode_error, o_string_done,
//           |                        | o_char_count
//
// one byte per cycle sustained while the output does not stall; a byte is written to the queue at the edge that
// takes it, and its result, if any, is loaded into the result register when the byte is popped
// the sequencer state update is the loop that sets the rate
// reset is synchronous, active low, and clears the queue and all string state
// output stall holds the result register; the two-entry queue absorbs the
// lag before the input stalls
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core
    import u8sd_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_last_byte,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [CODE_POINT_W-1:0]       o_code_point,
    output logic                          o_char_valid,
    output logic                          o_decode_error,
    output logic                          o_string_done,
    output logic [CHAR_COUNT_W-1:0]       o_char_count
);

    t_tok w_push_tok;
    t_tok w_pop_tok;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    u8sd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_tok       (w_push_tok)
    );

    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_push_tok),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_tok   (w_pop_tok)
    );

    u8sd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_empty),
        .i_tok          (w_pop_tok),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_code_point   (o_code_point),
        .o_char_valid   (o_char_valid),
        .o_decode_error (o_decode_error),
        .o_string_done  (o_string_done),
        .o_char_count   (o_char_count)
    );

endmodule : utf8_stream_decoder_core

`default_nettype wire

FILE: rtl/core/u8sd_front.sv
// u8sd_front: takes input beats and classifies each byte into a token
// depends on u8sd_pkg; pushes into u8sd_queue
`timescale 1ns / 1ps
`default_nettype none

module u8sd_front
    import u8sd_pkg::*;
(
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output t_tok            o_tok
);

    logic [7:0] w_b;

    assign w_b        = i_data_byte;
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_tok          = '0;
        o_tok.last     = i_last_byte;
        o_tok.kind     = TK_BAD;
        o_tok.lead_len = 3'd0;
        o_tok.bits     = '0;
        priority if (w_b == 8'h00) begin
            o_tok.kind = TK_ZERO;
        end else if (w_b <= ASCII_MAX) begin
            o_tok.kind = TK_ASCII;
            o_tok.bits = w_b[6:0];
        end else if ((w_b & CONT_MASK) == CONT_TAG) begin
            o_tok.kind = TK_CONT;
            o_tok.bits = {1'b0, w_b[5:0] & CONT_BITS[5:0]};
        end else if (w_b >= LEAD2_MIN && w_b < LEAD3_MIN) begin
            o_tok.kind     = TK_LEAD;
            o_tok.lead_len = 3'd1;
            o_tok.bits     = {2'b00, w_b[4:0]};
        end else if (w_b >= LEAD3_MIN && w_b < LEAD4_MIN) begin
            o_tok.kind     = TK_LEAD;
            o_tok.lead_len = 3'd2;
            o_tok.bits     = {3'b000, w_b[3:0]};
        end else if (w_b >= LEAD4_MIN && w_b < LEAD5_MIN) begin
            o_tok.kind     = TK_LEAD;
            o_tok.lead_len = 3'd3;
            o_tok.bits     = {4'b0000, w_b[2:0]};
        end else if (w_b >= LEAD5_MIN && w_b < LEAD6_MIN) begin
            o_tok.kind     = TK_LEAD;
            o_tok.lead_len = 3'd4;
            o_tok.bits     = {5'b00000, w_b[1:0]};
        end else if (w_b >= LEAD6_MIN && w_b <= LEAD6_MAX) begin
            o_tok.kind     = TK_LEAD;
            o_tok.lead_len = 3'd5;
            o_tok.bits     = {6'b000000, w_b[0]};
        end else begin
            o_tok.kind = TK_BAD;
        end
    end

endmodule : u8sd_front

`default_nettype wire

FILE: rtl/core/u8sd_queue.sv
// u8sd_queue: two-entry token queue between classifier and sequencer
// depends on u8sd_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8sd_queue
    import u8sd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_tok,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_tok      o_tok
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_tok            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CntW'(QUEUE_DEPTH)) == (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule : u8sd_queue

`default_nettype wire

FILE: rtl/core/u8sd_back.sv
// u8sd_back: sequence state, code point assembly and the result register
// depends on u8sd_pkg; pops tokens from u8sd_queue
`timescale 1ns / 1ps
`default_nettype none

module u8sd_back
    import u8sd_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_empty,
    input  wire t_tok                     i_tok,
    output logic                          o_pop,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic [CODE_POINT_W-1:0]       o_code_point,
    output logic                          o_char_valid,
    output logic                          o_decode_error,
    output logic                          o_string_done,
    output logic [CHAR_COUNT_W-1:0]       o_char_count
);

    localparam int ExtW = (COUNT_BITS > CHAR_COUNT_W) ? COUNT_BITS : CHAR_COUNT_W;
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    logic [2:0]              r_pend,    n_pend;
    logic [CODE_POINT_W-1:0] r_partial, n_partial;
    logic [COUNT_BITS-1:0]   r_count,   n_count;
    logic                    r_err,     n_err;
    logic                    r_disc,    n_disc;

    logic                    r_out_valid;
    logic [CODE_POINT_W-1:0] r_out_cp;
    logic                    r_out_char;
    logic                    r_out_err;
    logic                    r_out_done;
    logic [CHAR_COUNT_W-1:0] r_out_count;

    logic                    w_got;
    logic                    w_done;
    logic [CODE_POINT_W-1:0] w_cp;
    logic [CODE_POINT_W-1:0] w_shift;
    logic [ExtW-1:0]         w_count_ext;
    logic                    w_load;

    // result register frees up when it is empty or its beat is taken
    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    assign w_shift     = {r_partial[CODE_POINT_W-7:0], i_tok.bits[5:0]};
    assign w_count_ext = ExtW'(n_count);

    always_comb begin
        n_pend    = r_pend;
        n_partial = r_partial;
        n_count   = r_count;
        n_err     = r_err;
        n_disc    = r_disc;
        w_got     = 1'b0;
        w_done    = 1'b0;
        w_cp      = '0;
        if (i_tok.kind == TK_ZERO) begin
            if (!r_disc && r_pend != 3'd0) begin
                n_err     = 1'b1;
                n_disc    = 1'b1;
                n_pend    = 3'd0;
                n_partial = '0;
            end
            w_done = 1'b1;
        end else begin
            if (!r_disc) begin
                if (r_pend == 3'd0) begin
                    unique case (i_tok.kind)
                        TK_ASCII: begin
                            w_got = 1'b1;
                            w_cp  = CODE_POINT_W'(i_tok.bits);
                        end
                        TK_LEAD: begin
                            n_partial = CODE_POINT_W'(i_tok.bits);
                            n_pend    = i_tok.lead_len;
                        end
                        default: begin
                            n_err     = 1'b1;
                            n_disc    = 1'b1;
                            n_pend    = 3'd0;
                            n_partial = '0;
                        end
                    endcase
                end else if (i_tok.kind == TK_CONT) begin
                    n_pend = r_pend - 3'd1;
                    if (r_pend == 3'd1) begin
                        w_got     = 1'b1;
                        w_cp      = w_shift;
                        n_partial = '0;
                    end else begin
                        n_partial = w_shift;
                    end
                end else begin
                    n_err     = 1'b1;
                    n_disc    = 1'b1;
                    n_pend    = 3'd0;
                    n_partial = '0;
                end
                if (w_got && r_count != CountMax) begin
                    n_count = r_count + 1'b1;
                end
            end
            if (i_tok.last) begin
                // string ends with a sequence still open
                if (!n_disc && n_pend != 3'd0) begin
                    n_err     = 1'b1;
                    n_disc    = 1'b1;
                    n_pend    = 3'd0;
                    n_partial = '0;
                end
                w_done = 1'b1;
            end
        end
    end

    assign w_load = o_pop && (w_got || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 3'd0;
            r_partial <= '0;
            r_count   <= '0;
            r_err     <= 1'b0;
            r_disc    <= 1'b0;
        end else if (o_pop) begin
            if (w_done) begin
                r_pend    <= 3'd0;
                r_partial <= '0;
                r_count   <= '0;
                r_err     <= 1'b0;
                r_disc    <= 1'b0;
            end else begin
                r_pend    <= n_pend;
                r_partial <= n_partial;
                r_count   <= n_count;
                r_err     <= n_err;
                r_disc    <= n_disc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_cp    <= w_cp;
            r_out_char  <= w_got;
            r_out_err   <= n_err;
            r_out_done  <= w_done;
            r_out_count <= w_count_ext[CHAR_COUNT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_point   = r_out_cp;
    assign o_char_valid   = r_out_char;
    assign o_decode_error = r_out_err;
    assign o_string_done  = r_out_done;
    assign o_char_count   = r_out_count;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd5) else $error("pending count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_err && r_pend == 3'd0 && r_partial == '0))
        else $error("discard state inconsistent");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_char && !r_out_err))
        else $error("mid-string beat without a character");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("result register overwritten while stalled");

endmodule : u8sd_back

`default_nettype wire

FILE: test/utf8_stream_decoder_core_tb.sv
// utf8_stream_decoder_core_tb: self-checking bench for the six-byte utf-8 stream decoder
// scoreboard class predicts each beat from accepted bytes; initial blocks drive both channels
// depends on u8sd_pkg and utf8_stream_decoder_core
`timescale 1ns / 1ps

import u8sd_pkg::*;

localparam int DEC_COUNT_BITS = 20;

typedef struct packed {
    logic [CODE_POINT_W-1:0] code_point;
    logic                    char_valid;
    logic                    decode_error;
    logic                    string_done;
    logic [CHAR_COUNT_W-1:0] char_count;
} t_char_beat;

class decode_scoreboard;
    logic [2:0]                cont_left;
    logic [CODE_POINT_W-1:0]   partial_cp;
    logic [DEC_COUNT_BITS-1:0] char_total;
    logic                      bad_seq;
    logic                      skipping;
    t_char_beat                pending_chars[$];
    int                        mismatches;
    int                        strings_closed;
    int                        chars_checked;
    int                        bad_strings;

    function new();
        restart();
        mismatches     = 0;
        strings_closed = 0;
        chars_checked  = 0;
        bad_strings    = 0;
    endfunction

    function void restart();
        cont_left  = '0;
        partial_cp = '0;
        char_total = '0;
        bad_seq    = 1'b0;
        skipping   = 1'b0;
    endfunction

    function void flag_error();
        bad_seq    = 1'b1;
        skipping   = 1'b1;
        cont_left  = '0;
        partial_cp = '0;
    endfunction

    // predicts the beat caused by one accepted byte; returns 0 when the byte is ignored
    function bit take_byte(logic [7:0] b, logic is_last);
        t_char_beat beat;
        bit         got_char;
        bit         closes;
        bit         live;
        beat     = '0;
        got_char = 1'b0;
        closes   = 1'b0;
        live     = !skipping || b == 8'h00 || is_last;
        if (b == 8'h00) begin
            if (!skipping && cont_left != 0)
                flag_error();
            closes = 1'b1;
        end else begin
            if (!skipping) begin
                if (cont_left == 0) begin
                    if (b <= ASCII_MAX) begin
                        beat.code_point = CODE_POINT_W'(b);
                        got_char = 1'b1;
                    end else if (b >= LEAD2_MIN && b < LEAD3_MIN) begin
                        partial_cp = CODE_POINT_W'(b & 8'h1F);
                        cont_left  = 3'd1;
                    end else if (b >= LEAD3_MIN && b < LEAD4_MIN) begin
                        partial_cp = CODE_POINT_W'(b & 8'h0F);
                        cont_left  = 3'd2;
                    end else if (b >= LEAD4_MIN && b < LEAD5_MIN) begin
                        partial_cp = CODE_POINT_W'(b & 8'h07);
                        cont_left  = 3'd3;
                    end else if (b >= LEAD5_MIN && b < LEAD6_MIN) begin
                        partial_cp = CODE_POINT_W'(b & 8'h03);
                        cont_left  = 3'd4;
                    end else if (b >= LEAD6_MIN && b <= LEAD6_MAX) begin
                        partial_cp = CODE_POINT_W'(b & 8'h01);
                        cont_left  = 3'd5;
                    end else begin
                        flag_error();
                    end
                end else if ((b & CONT_MASK) == CONT_TAG) begin
                    // top bits fall off the 31-bit value
                    partial_cp = {partial_cp[CODE_POINT_W-7:0], b[5:0]};
                    cont_left  = cont_left - 3'd1;
                    if (cont_left == 0) begin
                        beat.code_point = partial_cp;
                        partial_cp = '0;
                        got_char = 1'b1;
                    end
                end else begin
                    flag_error();
                end
                if (got_char && char_total != '1)
                    char_total = char_total + 1'b1;
            end
            if (is_last) begin
                if (!skipping && cont_left != 0)
                    flag_error();
                closes = 1'b1;
            end
        end
        if (got_char || closes) begin
            beat.char_valid   = got_char;
            beat.decode_error = bad_seq;
            beat.string_done  = closes;
            beat.char_count   = CHAR_COUNT_W'(char_total);
            pending_chars.push_back(beat);
        end
        if (closes)
            restart();
        return live;
    endfunction

    task report_mismatch(string msg);
        if (mismatches < 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_char(t_char_beat seen);
        t_char_beat want;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected: cp %h valid %b done %b",
                                      seen.code_point, seen.char_valid, seen.string_done));
            return;
        end
        want = pending_chars.pop_front();
        if (seen.code_point !== want.code_point)
            report_mismatch($sformatf("code_point %h, expected %h",
                                      seen.code_point, want.code_point));
        if (seen.char_valid !== want.char_valid)
            report_mismatch($sformatf("char_valid %b, expected %b",
                                      seen.char_valid, want.char_valid));
        if (seen.decode_error !== want.decode_error)
            report_mismatch($sformatf("decode_error %b, expected %b",
                                      seen.decode_error, want.decode_error));
        if (seen.string_done !== want.string_done)
            report_mismatch($sformatf("string_done %b, expected %b",
                                      seen.string_done, want.string_done));
        if (seen.char_count !== want.char_count)
            report_mismatch($sformatf("char_count %0d, expected %0d",
                                      seen.char_count, want.char_count));
        if (want.char_valid)
            chars_checked++;
        if (want.string_done)
            strings_closed++;
        if (want.string_done && want.decode_error)
            bad_strings++;
    endtask
endclass

module utf8_stream_decoder_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic [7:0]              i_data_byte  = 8'h00;
    logic                    i_last_byte  = 1'b0;
    logic                    i_out_stall  = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [CODE_POINT_W-1:0] o_code_point;
    logic                    o_char_valid;
    logic                    o_decode_error;
    logic                    o_string_done;
    logic [CHAR_COUNT_W-1:0] o_char_count;

    decode_scoreboard decoder_sb = new();
    logic [8:0]       string_beats[$];  // {last flag, byte}
    int unsigned      send_idle_pct = 29;
    int unsigned      recv_idle_pct = 85;
    int               live_beats    = 0;
    int               bytes_sent    = 0;
    int unsigned      cycles        = 0;
    bit               hold_request  = 1'b0;

    utf8_stream_decoder_core #(
        .COUNT_BITS(DEC_COUNT_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code_point   (o_code_point),
        .o_char_valid   (o_char_valid),
        .o_decode_error (o_decode_error),
        .o_string_done  (o_string_done),
        .o_char_count   (o_char_count)
    );

    always #6 i_clk = ~i_clk;

    // outputs are sampled mid-cycle, where nothing is changing
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            decoder_sb.check_char({o_code_point, o_char_valid, o_decode_error,
                                   o_string_done, o_char_count});
    end

    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        bytes_sent++;
        if (decoder_sb.take_byte(b, is_last))
            live_beats++;
    endtask

    // lead byte of a len-byte character plus keep-1 continuation bytes
    function automatic void queue_char(int len, int keep);
        logic [7:0] lead;
        case (len)
            1:       lead = 8'($urandom_range(1, ASCII_MAX));
            2:       lead = LEAD2_MIN | 8'($urandom_range(0, 31));
            3:       lead = LEAD3_MIN | 8'($urandom_range(0, 15));
            4:       lead = LEAD4_MIN | 8'($urandom_range(0, 7));
            5:       lead = LEAD5_MIN | 8'($urandom_range(0, 3));
            default: lead = LEAD6_MIN | 8'($urandom_range(0, 1));
        endcase
        string_beats.push_back({1'b0, lead});
        for (int i = 1; i < keep; i++)
            string_beats.push_back({1'b0, CONT_TAG | 8'($urandom_range(0, 63))});
    endfunction

    task automatic send_random_string();
        int kind;
        int len;
        string_beats = {};
        kind = $urandom_range(99);
        if (kind < 94) begin
            repeat (($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5)) begin
                len = $urandom_range(1, 6);
                queue_char(len, len);
            end
        end
        if (kind >= 72 && kind < 88) begin
            // sequence cut short, then either the end or a bad continuation
            len = $urandom_range(2, 6);
            queue_char(len, $urandom_range(1, len - 1));
            if (kind >= 80)
                string_beats.push_back({1'b0, $urandom_range(1) ?
                                        8'($urandom_range(1, 8'h7F)) :
                                        8'($urandom_range(8'hC0, 8'hFF))});
        end else if (kind >= 88 && kind < 94) begin
            string_beats.push_back({1'b0, $urandom_range(2) == 0 ?
                                    8'($urandom_range(8'hFE, 8'hFF)) :
                                    8'($urandom_range(8'h80, 8'hBF))});
        end
        if (kind >= 80)
            repeat ($urandom_range(kind >= 94 ? 1 : 0, 8))
                string_beats.push_back({1'b0, 8'($urandom_range(1, 255))});
        if (string_beats.size() != 0 && $urandom_range(99) < 55)
            string_beats[string_beats.size() - 1][8] = 1'b1;
        else
            string_beats.push_back({($urandom_range(3) == 0), 8'h00});
        foreach (string_beats[i])
            send_byte(string_beats[i][7:0], string_beats[i][8]);
    endtask

    initial begin : stimulus
        logic [8:0] directed_beats[$];
        directed_beats = '{
            9'h07F,                                         // ascii max
            9'h0DF, 9'h0BF,                                 // two-byte max
            9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, // six-byte max
            9'h0BF, 9'h041, 9'h000,                         // stray continuation, dropped, zero
            9'h0E0, 9'h041, 9'h1FE,                         // bad continuation, close on last
            9'h0F0, 9'h000,                                 // cut short by zero
            9'h101,                                         // ascii with last
            9'h0F8, 9'h180,                                 // cut short by last
            9'h1FF,                                         // bad lead with last
            9'h000,                                         // empty string
            9'h0C2, 9'h180                                  // last beat completes a char
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_beats[i])
            send_byte(directed_beats[i][7:0], directed_beats[i][8]);

        while (bytes_sent < 480)
            send_random_string();
        send_idle_pct = 85;
        recv_idle_pct = 29;
        while (bytes_sent < 960)
            send_random_string();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;  // long output hold-off so the input backs up
        while (bytes_sent < 1450)
            send_random_string();
        i_in_valid <= 1'b0;

        while (decoder_sb.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes (%0d not ignored) in %0d cycles", bytes_sent, live_beats,
                 cycles);
        $display("checked %0d code points over %0d strings, %0d of them flagged bad",
                 decoder_sb.chars_checked, decoder_sb.strings_closed, decoder_sb.bad_strings);
        if (decoder_sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/u8sd_pkg.sv
rtl/core/u8sd_front.sv
rtl/core/u8sd_queue.sv
rtl/core/u8sd_back.sv
rtl/core/utf8_stream_decoder_core.sv
test/utf8_stream_decoder_core_tb.sv
